[hw/rtl/apdu_multi_frame_reassembler_defines.svh]
// Assertion macros for the multi-frame reassembler.
`ifndef APDU_MULTI_FRAME_REASSEMBLER_DEFINES_SVH
`define APDU_MULTI_FRAME_REASSEMBLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AMFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define AMFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define AMFR_ASSERT_SAME(label, ante, cons)
`define AMFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/amfr_pkg.sv]
// Shared types and constants for the multi-frame reassembler.
package amfr_pkg;

    localparam int HEADER_BYTES   = 5;
    localparam int WORD_BYTES     = 8;
    localparam int WORDS_PER_SLOT = 8;
    localparam int DATA_CAP       = 59;
    localparam int LEN_W          = 6;
    localparam int WSEL_W         = 3;

    typedef enum logic [2:0] {
        ST_WAIT      = 3'd0,
        ST_DUP       = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_INCONS    = 3'd4,
        ST_MESSAGE   = 3'd5
    } status_t;

    typedef struct packed {
        logic                capture;
        logic                commit;
        logic                write_en;
        logic [WSEL_W-1:0]   word_sel;
        logic                drain_start;
        logic                drain;
        logic                clear;
        logic                emit_single;
        status_t             code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic    ok;
        status_t code;
        logic    complete;
        logic    empty;
        logic    drain_last;
    } dp_status_t;

endpackage

[hw/rtl/amfr_ctrl.sv]
// Controller state machine for the multi-frame reassembler.
module amfr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  amfr_pkg::dp_status_t sts,
    output amfr_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_STORE,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                        state_reg, state_next;
    logic [amfr_pkg::WSEL_W-1:0]   word_reg, word_next;
    logic                          busy_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.code   = amfr_pkg::ST_WAIT;
        state_next = state_reg;
        word_next  = word_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!sts.ok)
                begin
                    cmd.emit_single = 1'b1;
                    cmd.code        = sts.code;
                    // A duplicate leaves the open sequence untouched.
                    cmd.clear       = (sts.code != amfr_pkg::ST_DUP);
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    word_next  = '0;
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.write_en = 1'b1;
                cmd.word_sel = word_reg;
                word_next    = word_reg + 1'b1;
                if (word_reg == amfr_pkg::WSEL_W'(amfr_pkg::WORDS_PER_SLOT - 1))
                begin
                    if (!sts.complete)
                    begin
                        cmd.emit_single = 1'b1;
                        cmd.code        = amfr_pkg::ST_WAIT;
                        state_next      = S_FINISH;
                    end
                    else if (sts.empty)
                    begin
                        cmd.emit_single = 1'b1;
                        cmd.code        = amfr_pkg::ST_MESSAGE;
                        cmd.clear       = 1'b1;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cmd.drain_start = 1'b1;
                        state_next      = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                cmd.drain = 1'b1;
                if (sts.drain_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            word_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[hw/rtl/amfr_datapath.sv]
// Datapath: frame capture, payload memory, slot bookkeeping and output aligner.
module amfr_datapath
#(
    parameter int MAX_SLOTS   = 8,
    parameter int FRAME_BYTES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  amfr_pkg::ctrl_cmd_t  cmd,
    output amfr_pkg::dp_status_t sts,
    input  logic [6:0]           frame_length,
    input  logic [7:0]           command,
    input  logic [7:0]           total_frames,
    input  logic [7:0]           frame_index,
    input  logic [63:0]          data_word_0,
    input  logic [63:0]          data_word_1,
    input  logic [63:0]          data_word_2,
    input  logic [63:0]          data_word_3,
    input  logic [63:0]          data_word_4,
    input  logic [63:0]          data_word_5,
    input  logic [63:0]          data_word_6,
    input  logic [63:0]          data_word_7,
    output logic                 result_valid,
    output logic [2:0]           status,
    output logic [7:0]           message_command,
    output logic [63:0]          message_word,
    output logic [3:0]           valid_bytes,
    output logic [8:0]           message_length,
    output logic                 last
);

    localparam int LEN_W       = amfr_pkg::LEN_W;
    localparam int WSEL_W      = amfr_pkg::WSEL_W;
    localparam int PAYLOAD_MAX = (FRAME_BYTES - amfr_pkg::HEADER_BYTES) < amfr_pkg::DATA_CAP ?
                                 (FRAME_BYTES - amfr_pkg::HEADER_BYTES) : amfr_pkg::DATA_CAP;
    localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int EXP_W       = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W      = SLOT_W + WSEL_W;
    localparam int DEPTH       = MAX_SLOTS * amfr_pkg::WORDS_PER_SLOT;
    localparam int TOTAL_W     = $clog2(MAX_SLOTS * PAYLOAD_MAX + 1);

    // Captured frame.
    logic [6:0]             flen_reg;
    logic [7:0]             cmd_reg;
    logic [7:0]             tot_reg;
    logic [7:0]             idx_reg;
    logic [63:0]            data_reg [amfr_pkg::WORDS_PER_SLOT];

    // Sequence state.
    logic [LEN_W-1:0]       slot_len_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]   map_reg;
    logic [EXP_W-1:0]       exp_reg;
    logic [TOTAL_W-1:0]     total_reg;

    // Payload memory.
    logic [63:0]            mem [DEPTH];
    logic [63:0]            mem_q;

    // Drain walk and aligner.
    logic [CNT_W-1:0]       slot_reg;
    logic [WSEL_W-1:0]      wrd_reg;
    logic                   rd_vld_reg;
    logic [3:0]             rd_n_reg;
    logic [63:0]            acc_reg;
    logic [3:0]             acc_cnt_reg;
    logic [TOTAL_W-1:0]     rem_reg;

    // Result registers.
    logic                   out_vld_reg;
    amfr_pkg::status_t      out_status_reg;
    logic [7:0]             out_cmd_reg;
    logic [63:0]            out_word_reg;
    logic [3:0]             out_valid_reg;
    logic [8:0]             out_len_reg;
    logic                   out_last_reg;

    // Frame checks.
    logic [6:0]             plen_raw;
    logic [LEN_W-1:0]       plen;
    logic                   is_short;
    logic                   is_bad;
    logic                   opening;
    logic                   is_incons;
    logic [SLOT_W-1:0]      idx_s;
    logic                   is_dup;
    logic [MAX_SLOTS-1:0]   full;

    // Store path.
    logic [ADDR_W-1:0]      waddr;
    logic [63:0]            wdata;
    logic [63:0]            wsrc;

    // Walk path.
    logic                   walk_done;
    logic [SLOT_W-1:0]      slot_s;
    logic [LEN_W-1:0]       cur_len;
    logic [LEN_W-1:0]       base;
    logic [LEN_W-1:0]       left;
    logic [3:0]             take_n;
    logic                   slot_end;
    logic                   rd_issue;
    logic [ADDR_W-1:0]      raddr;

    // Aligner path.
    logic [63:0]            din;
    logic [3:0]             in_n;
    logic [3:0]             sum;
    logic [127:0]           merged;
    logic [3:0]             need;
    logic                   emit;
    logic                   drain_last;

    always_comb
    begin
        plen_raw  = flen_reg - 7'(amfr_pkg::HEADER_BYTES);
        plen      = (plen_raw > 7'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : plen_raw[LEN_W-1:0];
        is_short  = flen_reg < 7'(amfr_pkg::HEADER_BYTES);
        is_bad    = (tot_reg > 8'(MAX_SLOTS)) || (idx_reg >= tot_reg);
        opening   = (idx_reg == 8'd0) && (exp_reg == '0);
        is_incons = !opening && (tot_reg != 8'(exp_reg));
        idx_s     = idx_reg[SLOT_W-1:0];
        is_dup    = map_reg[idx_s];
        for (int b = 0; b < MAX_SLOTS; b++)
        begin
            full[b] = (b < int'(exp_reg));
        end
    end

    always_comb
    begin
        sts.ok         = 1'b0;
        sts.code       = amfr_pkg::ST_WAIT;
        if (is_short)
        begin
            sts.code = amfr_pkg::ST_SHORT;
        end
        else if (is_bad)
        begin
            sts.code = amfr_pkg::ST_BAD_INDEX;
        end
        else if (is_incons)
        begin
            sts.code = amfr_pkg::ST_INCONS;
        end
        else if (is_dup)
        begin
            sts.code = amfr_pkg::ST_DUP;
        end
        else
        begin
            sts.ok = 1'b1;
        end
        sts.complete   = ((map_reg & full) == full);
        sts.empty      = (total_reg == '0);
        sts.drain_last = drain_last;
    end

    // Store path: bytes past the payload length are written as zero, which the
    // aligner relies on when it merges partial words.
    always_comb
    begin
        waddr = {idx_s, cmd.word_sel};
        wsrc  = data_reg[cmd.word_sel];
        for (int b = 0; b < amfr_pkg::WORD_BYTES; b++)
        begin
            wdata[8*b +: 8] = ({cmd.word_sel, 3'(b)} < plen) ? wsrc[8*b +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        walk_done = (int'(slot_reg) >= int'(exp_reg));
        slot_s    = slot_reg[SLOT_W-1:0];
        cur_len   = slot_len_reg[slot_s];
        base      = {wrd_reg, 3'b000};
        left      = cur_len - base;
        take_n    = (left >= LEN_W'(amfr_pkg::WORD_BYTES)) ? 4'd8 : left[3:0];
        slot_end  = (left <= LEN_W'(amfr_pkg::WORD_BYTES));
        rd_issue  = cmd.drain && !walk_done && (cur_len != '0);
        raddr     = {slot_s, wrd_reg};
    end

    always_comb
    begin
        din        = rd_vld_reg ? mem_q : 64'd0;
        in_n       = rd_vld_reg ? rd_n_reg : 4'd0;
        sum        = acc_cnt_reg + in_n;
        merged     = {64'd0, acc_reg} | ({64'd0, din} << {acc_cnt_reg, 3'b000});
        need       = (rem_reg >= TOTAL_W'(amfr_pkg::WORD_BYTES)) ? 4'd8 : 4'(rem_reg);
        emit       = cmd.drain && (rem_reg != '0) && (sum >= need);
        drain_last = emit && (rem_reg == TOTAL_W'(need));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_issue)
        begin
            mem_q <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            flen_reg    <= frame_length;
            cmd_reg     <= command;
            tot_reg     <= total_frames;
            idx_reg     <= frame_index;
            data_reg[0] <= data_word_0;
            data_reg[1] <= data_word_1;
            data_reg[2] <= data_word_2;
            data_reg[3] <= data_word_3;
            data_reg[4] <= data_word_4;
            data_reg[5] <= data_word_5;
            data_reg[6] <= data_word_6;
            data_reg[7] <= data_word_7;
        end
        if (cmd.drain_start)
        begin
            acc_reg <= '0;
        end
        else if (emit)
        begin
            acc_reg <= merged[127:64];
        end
        else if (cmd.drain)
        begin
            acc_reg <= merged[63:0];
        end
        if (cmd.drain)
        begin
            rd_n_reg <= take_n;
        end
        if (cmd.emit_single)
        begin
            out_status_reg <= cmd.code;
            out_cmd_reg    <= (cmd.code == amfr_pkg::ST_MESSAGE) ? cmd_reg : 8'd0;
            out_word_reg   <= '0;
            out_valid_reg  <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (emit)
        begin
            out_status_reg <= amfr_pkg::ST_MESSAGE;
            out_cmd_reg    <= cmd_reg;
            out_word_reg   <= merged[63:0];
            out_valid_reg  <= need;
            out_len_reg    <= 9'(total_reg);
            out_last_reg   <= drain_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                slot_len_reg[s] <= '0;
            end
            map_reg     <= '0;
            exp_reg     <= '0;
            total_reg   <= '0;
            slot_reg    <= '0;
            wrd_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            acc_cnt_reg <= '0;
            rem_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= cmd.emit_single || emit;
            if (cmd.clear)
            begin
                for (int s = 0; s < MAX_SLOTS; s++)
                begin
                    slot_len_reg[s] <= '0;
                end
                map_reg   <= '0;
                exp_reg   <= '0;
                total_reg <= '0;
            end
            else if (cmd.commit)
            begin
                if (opening)
                begin
                    exp_reg <= EXP_W'(tot_reg);
                end
                map_reg[idx_s]      <= 1'b1;
                slot_len_reg[idx_s] <= plen;
                total_reg           <= total_reg + TOTAL_W'(plen);
            end

            if (cmd.drain_start)
            begin
                slot_reg    <= '0;
                wrd_reg     <= '0;
                rd_vld_reg  <= 1'b0;
                acc_cnt_reg <= '0;
                rem_reg     <= total_reg;
            end
            else if (cmd.drain)
            begin
                rd_vld_reg <= rd_issue;
                if (!walk_done)
                begin
                    // Empty slots are skipped without a memory read.
                    if ((cur_len == '0) || slot_end)
                    begin
                        slot_reg <= slot_reg + 1'b1;
                        wrd_reg  <= '0;
                    end
                    else
                    begin
                        wrd_reg <= wrd_reg + 1'b1;
                    end
                end
                if (emit)
                begin
                    acc_cnt_reg <= sum - need;
                    rem_reg     <= rem_reg - TOTAL_W'(need);
                end
                else
                begin
                    acc_cnt_reg <= sum;
                end
            end
        end
    end

    assign result_valid    = out_vld_reg;
    assign status          = out_status_reg;
    assign message_command = out_cmd_reg;
    assign message_word    = out_word_reg;
    assign valid_bytes     = out_valid_reg;
    assign message_length  = out_len_reg;
    assign last            = out_last_reg;

endmodule

[hw/rtl/apdu_multi_frame_reassembler.sv]
// Top level of the multi-frame message reassembler.
//
//   Channel   Handshake                 Payload
//   frame     start / busy              frame_length, command, total_frames,
//                                       frame_index, data_word_0..7
//   result    result_valid (strobe)     status, message_command, message_word,
//                                       valid_bytes, message_length, last
//
// A stored frame keeps busy high through a check state, eight payload-memory
// writes (one write port) and a result state; a rejected or duplicate frame through the check and result states.
// The next transaction is accepted as soon as busy is low.
// A completing frame adds the drain, which walks each stored payload word and empty
// slot in turn through the single read port of the payload memory.
// Reset clears the sequence state but not the payload memory; results cannot be stalled.
`include "apdu_multi_frame_reassembler_defines.svh"

module apdu_multi_frame_reassembler
#(
    parameter int MAX_SLOTS   = 8,
    parameter int FRAME_BYTES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [6:0]  frame_length,
    input  logic [7:0]  command,
    input  logic [7:0]  total_frames,
    input  logic [7:0]  frame_index,
    input  logic [63:0] data_word_0,
    input  logic [63:0] data_word_1,
    input  logic [63:0] data_word_2,
    input  logic [63:0] data_word_3,
    input  logic [63:0] data_word_4,
    input  logic [63:0] data_word_5,
    input  logic [63:0] data_word_6,
    input  logic [63:0] data_word_7,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [7:0]  message_command,
    output logic [63:0] message_word,
    output logic [3:0]  valid_bytes,
    output logic [8:0]  message_length,
    output logic        last
);

    amfr_pkg::ctrl_cmd_t  cmd;
    amfr_pkg::dp_status_t sts;

    amfr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    amfr_datapath
    #(
        .MAX_SLOTS   (MAX_SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .frame_length    (frame_length),
        .command         (command),
        .total_frames    (total_frames),
        .frame_index     (frame_index),
        .data_word_0     (data_word_0),
        .data_word_1     (data_word_1),
        .data_word_2     (data_word_2),
        .data_word_3     (data_word_3),
        .data_word_4     (data_word_4),
        .data_word_5     (data_word_5),
        .data_word_6     (data_word_6),
        .data_word_7     (data_word_7),
        .result_valid    (result_valid),
        .status          (status),
        .message_command (message_command),
        .message_word    (message_word),
        .valid_bytes     (valid_bytes),
        .message_length  (message_length),
        .last            (last)
    );

    // An accepted transaction keeps the block busy on the following cycle.
    `AMFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // Nothing follows the final result of a transaction directly.
    `AMFR_ASSERT_NEXT(a_last_gap, result_valid && last, !result_valid)
    // Status-only results are always single.
    `AMFR_ASSERT_SAME(a_single_last, result_valid && (status != 3'(amfr_pkg::ST_MESSAGE)), last)
    // A partial message word can only be the final one.
    `AMFR_ASSERT_SAME(a_partial_last, result_valid && (valid_bytes != 4'd8), last)

endmodule
